>>> hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = 11;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [2:0] OP_SIZE       = 3'd6;
    localparam logic [2:0] OP_CLEAR      = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [COUNT_W-1:0] count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

>>> hdl/deq_ctrl.sv
// Transaction sequencer for the double-ended queue.
module deq_ctrl import deq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_strobe,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_strobe;
    logic   accept;

    assign accept = start && !r_busy;

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = accept ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state == S_EXEC);
            r_strobe <= (n_state == S_RESP);
        end
    end

    assign busy       = r_busy;
    assign o_strobe   = r_strobe;
    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

>>> hdl/deq_dp.sv
// Datapath of the double-ended queue: word memory, pointers, count, result.
module deq_dp import deq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    input  t_req    i_req,
    output t_rsp    o_rsp
);

    logic [31:0]        mem [DEPTH];

    logic [2:0]         r_op;
    logic [31:0]        r_value;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [ADDR_W-1:0]  r_tail, n_tail;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]         r_status, n_status;
    logic               r_rd_ok;
    logic [31:0]        r_rdata;

    logic               empty, full;
    logic               we, re;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  head_prev, head_next, tail_prev, tail_next;

    assign empty = (r_count == '0);
    assign full  = (r_count >= COUNT_W'(DEPTH));

    assign head_prev = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_next = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_prev = (r_tail == '0) ? ADDR_W'(DEPTH - 1) : r_tail - 1'b1;
    assign tail_next = (r_tail == ADDR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = ST_OK;
        we       = 1'b0;
        re       = 1'b0;
        addr     = r_head;
        case (r_op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    addr    = head_prev;
                    n_head  = head_prev;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    addr    = r_tail;
                    n_tail  = tail_next;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re      = 1'b1;
                    addr    = r_head;
                    n_head  = head_next;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re      = 1'b1;
                    addr    = tail_prev;
                    n_tail  = tail_prev;
                    n_count = r_count - 1'b1;
                end
            end
            OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re   = 1'b1;
                    addr = r_head;
                end
            end
            OP_PEEK_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re   = 1'b1;
                    addr = tail_prev;
                end
            end
            OP_SIZE: begin
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Hold the request for the execute cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_req.opcode;
            r_value <= i_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we) begin
                mem[addr] <= r_value;
            end
            if (re) begin
                r_rdata <= mem[addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
            r_rd_ok  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_status <= n_status;
            r_rd_ok  <= re;
        end
    end

    assign o_rsp.status = r_status;
    assign o_rsp.data   = r_rd_ok ? r_rdata : '0;
    assign o_rsp.count  = r_count;

endmodule

>>> hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
//
// A transaction is accepted at a clock edge where start is high and busy is
// low. The next cycle executes it against a single-port word memory of 1024
// entries (one read or one write) and updates the head and tail pointers and
// the count; the cycle after that carries the result on o_rsp with o_strobe
// high for exactly one cycle. The receiver cannot stall: a result that is
// not taken in its strobe cycle is gone. busy is low during the result
// cycle, so a new transaction may be accepted there; while busy is high in
// the execute cycle, start is ignored. No clearing pass is needed after
// reset; the block accepts work in the first cycle out of reset.
module double_ended_queue import deq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    t_dp_cmd cmd;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    deq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

>>> tb/deque_checker.sv
// Checker for the double-ended queue: predicts each result and compares it.
`timescale 1ns / 1ps

module deque_checker import deq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_strobe,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_refusals,
    output int   o_empty_refusals
);

    logic signed [31:0] deque_words [0:DEPTH-1];
    logic [ADDR_W-1:0]  front_slot;
    logic [ADDR_W-1:0]  back_slot;
    logic [COUNT_W-1:0] word_total;
    t_rsp               expected_rsps [$];

    function automatic logic [ADDR_W-1:0] slot_after(logic [ADDR_W-1:0] slot);
        return (slot == ADDR_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_before(logic [ADDR_W-1:0] slot);
        return (slot == '0) ? ADDR_W'(DEPTH - 1) : slot - 1'b1;
    endfunction

    // Apply one request to the predicted deque and return its result.
    function automatic t_rsp predict_result(t_req req);
        t_rsp rsp;
        logic is_empty;
        logic is_full;
        is_empty   = (word_total == '0);
        is_full    = (word_total >= COUNT_W'(DEPTH));
        rsp.status = ST_OK;
        rsp.data   = '0;
        case (req.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (is_full) begin
                    rsp.status = ST_FULL;
                end else if (req.opcode == OP_PUSH_FRONT) begin
                    front_slot = slot_before(front_slot);
                    deque_words[front_slot] = req.value;
                    word_total = word_total + 1'b1;
                end else begin
                    deque_words[back_slot] = req.value;
                    back_slot  = slot_after(back_slot);
                    word_total = word_total + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (is_empty) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    case (req.opcode)
                        OP_POP_FRONT: begin
                            rsp.data   = deque_words[front_slot];
                            front_slot = slot_after(front_slot);
                            word_total = word_total - 1'b1;
                        end
                        OP_POP_BACK: begin
                            back_slot  = slot_before(back_slot);
                            rsp.data   = deque_words[back_slot];
                            word_total = word_total - 1'b1;
                        end
                        OP_PEEK_FRONT: rsp.data = deque_words[front_slot];
                        default:       rsp.data = deque_words[slot_before(back_slot)];
                    endcase
                end
            end
            OP_SIZE: begin
            end
            default: begin
                front_slot = '0;
                back_slot  = '0;
                word_total = '0;
            end
        endcase
        rsp.count = word_total;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            front_slot = '0;
            back_slot  = '0;
            word_total = '0;
            expected_rsps.delete();
            o_fail_count     = 0;
            o_pending        = 0;
            o_checked        = 0;
            o_full_refusals  = 0;
            o_empty_refusals = 0;
        end else begin
            // Check the result first: it always belongs to an older transaction.
            if (i_strobe) begin
                got = i_rsp;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: result with nothing expected: got %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = expected_rsps[0];
                    expected_rsps.delete(0);
                    o_checked++;
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.data !== want.data) begin
                        $display("%0t: data mismatch: expected %h actual %h",
                                 $time, want.data, got.data);
                        o_fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: count mismatch: expected %0d actual %0d",
                                 $time, want.count, got.count);
                        o_fail_count++;
                    end
                    if (want.status == ST_FULL)  o_full_refusals++;
                    if (want.status == ST_EMPTY) o_empty_refusals++;
                end
            end
            if (i_start && !i_busy) begin
                expected_rsps.insert(expected_rsps.size(), predict_result(i_req));
            end
            o_pending = expected_rsps.size();
        end
    end

endmodule

>>> tb/double_ended_queue_test.sv
// Top of the double-ended queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module double_ended_queue_test import deq_pkg::*; ();

    localparam int CYCLE_LIMIT = 200000;
    localparam int MIXED       = 0;
    localparam int FILLING     = 1;
    localparam int DRAINING    = 2;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_rsp o_rsp;

    int fail_count;
    int pending;
    int checked;
    int full_refusals;
    int empty_refusals;
    int cycle_count;
    int sent_count;
    logic idle_enabled;

    double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp)
    );

    deque_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req           (i_req),
        .i_strobe        (o_strobe),
        .i_rsp           (o_rsp),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_refusals (full_refusals),
        .o_empty_refusals(empty_refusals)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("double_ended_queue_test: FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] random_opcode(int phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            FILLING:  return (roll < 95) ? 3'($urandom_range(0, 1)) :
                                           3'($urandom_range(4, 6));
            DRAINING: return (roll < 70) ? 3'($urandom_range(2, 3)) :
                                           3'($urandom_range(0, 6));
            default:  return (roll < 3) ? OP_CLEAR : 3'($urandom_range(0, 6));
        endcase
    endfunction

    // Issue one transaction after a random gap and hold until it is taken.
    task automatic issue(logic [2:0] opcode, logic signed [31:0] value);
        int gap;
        gap = idle_enabled ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= {3'($urandom), 32'($urandom)};
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_req.opcode <= opcode;
        i_req.value  <= value;
        do @(posedge i_clk); while (busy);
        sent_count++;
        // Alternate stretches with and without idle gaps.
        if (sent_count % 64 == 0) idle_enabled = $urandom_range(0, 2) != 0;
    endtask

    task automatic run_phase(int phase, int item_total);
        repeat (item_total) issue(random_opcode(phase), random_word());
    endtask

    initial begin
        int pushes;
        logic [2:0] opcode;
        cycle_count  = 0;
        sent_count   = 0;
        idle_enabled = 1'b1;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty errors, extreme words, both ends, size and clear.
        issue(OP_POP_FRONT,  32'sd5);
        issue(OP_POP_BACK,   32'sd5);
        issue(OP_PEEK_FRONT, 32'sd0);
        issue(OP_PEEK_BACK,  32'sd0);
        issue(OP_SIZE,       32'sd0);
        issue(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        issue(OP_PUSH_BACK,  32'sh8000_0000);
        issue(OP_PUSH_FRONT, -32'sd1);
        issue(OP_PUSH_BACK,  32'sd0);
        issue(OP_PEEK_FRONT, 32'sd0);
        issue(OP_PEEK_BACK,  32'sd0);
        issue(OP_SIZE,       32'sh1234_5678);
        issue(OP_POP_BACK,   32'sd0);
        issue(OP_POP_FRONT,  32'sd0);
        issue(OP_PUSH_BACK,  32'sd1);
        issue(OP_CLEAR,      32'sd0);
        issue(OP_SIZE,       32'sd0);
        issue(OP_PEEK_BACK,  32'sd0);
        issue(OP_PUSH_BACK,  32'sh5555_5555);
        issue(OP_PUSH_FRONT, 32'shAAAA_AAAA);
        issue(OP_POP_FRONT,  32'sd0);
        issue(OP_POP_FRONT,  32'sd0);
        issue(OP_POP_FRONT,  32'sd0);

        run_phase(MIXED, 250);

        // Fill from empty past capacity so the last pushes are refused.
        issue(OP_CLEAR, random_word());
        pushes = 0;
        while (pushes < DEPTH + 4) begin
            opcode = random_opcode(FILLING);
            if (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK) pushes++;
            issue(opcode, random_word());
        end

        run_phase(DRAINING, 300);
        run_phase(MIXED, 200);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("%0d transactions sent, %0d results checked", sent_count, checked);
        $display("pushes refused on full: %0d, pops and peeks refused on empty: %0d",
                 full_refusals, empty_refusals);
        if (fail_count == 0) begin
            $display("double_ended_queue_test: PASS");
        end else begin
            $display("double_ended_queue_test: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_dp.sv
hdl/double_ended_queue.sv
tb/deque_checker.sv
tb/double_ended_queue_test.sv
